// File: src/iercl_pkg.sv
// Package for the ICMP error reply classifier: item structs, the per-packet
// record passed from the byte parser to the verdict stage, and header constants.
// No dependencies.
package iercl_pkg;

    // Header sizes and offsets, in bytes.
    localparam logic [15:0] IP_HDR_MIN   = 16'd20;
    localparam logic [15:0] ICMP_HDR_MIN = 16'd8;
    localparam logic [15:0] UDP_HDR      = 16'd8;

    // Byte offsets of fields inside headers.
    localparam logic [15:0] OFS_PROTOCOL  = 16'd9;
    localparam logic [15:0] OFS_SRC_BYTE0 = 16'd12;
    localparam logic [15:0] OFS_SRC_BYTE1 = 16'd13;
    localparam logic [15:0] OFS_SRC_BYTE2 = 16'd14;
    localparam logic [15:0] OFS_SRC_BYTE3 = 16'd15;
    localparam logic [15:0] OFS_CODE      = 16'd1;
    localparam logic [15:0] OFS_PORT_HI   = 16'd2;
    localparam logic [15:0] OFS_PORT_LO   = 16'd3;
    localparam logic [15:0] OFS_LEN_HI    = 16'd4;
    localparam logic [15:0] OFS_LEN_LO    = 16'd5;

    // Protocol numbers, ICMP types and codes.
    localparam logic [7:0] PROTO_UDP          = 8'd17;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] TYPE_UNREACHABLE   = 8'd3;
    localparam logic [7:0] CODE_PORT          = 8'd3;
    localparam logic [7:0] CODE_PROHIBITED    = 8'd13;

    // Register reset values.
    localparam logic [7:0]  RST_EXPECTED_PROTOCOL   = 8'd1;
    localparam logic [15:0] RST_EXPECTED_PORT       = 16'd0;
    localparam logic [15:0] RST_EXPECTED_UDP_LENGTH = 16'd12;

    // Depth of the queue between parser and verdict stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_EXPECTED_PROTOCOL   = 2'd0,
        CFG_EXPECTED_PORT       = 2'd1,
        CFG_EXPECTED_UDP_LENGTH = 2'd2
    } t_cfg_index;

    // Verdict codes.
    typedef enum logic [3:0] {
        VERDICT_SHORT       = 4'd0,
        VERDICT_WRONG_PROTO = 4'd1,
        VERDICT_IGNORED     = 4'd2,
        VERDICT_NOT_UDP     = 4'd3,
        VERDICT_MISMATCH    = 4'd4,
        VERDICT_VALID       = 4'd5,
        VERDICT_LAST_HOP    = 4'd6,
        VERDICT_FILTERED    = 4'd7,
        VERDICT_ABORT       = 4'd8
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] source_address;
        logic [15:0] reply_length;
    } t_out_item;

    // Everything captured from one packet.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [5:0]  outer_header_bytes;
        logic [7:0]  outer_protocol;
        logic [31:0] reply_source;
        logic [7:0]  message_type;
        logic [7:0]  message_code;
        logic [5:0]  inner_header_bytes;
        logic [7:0]  inner_protocol;
        logic [15:0] quoted_port;
        logic [15:0] quoted_length;
    } t_packet_rec;

endpackage

// File: src/icmp_error_reply_classifier.sv
// Top level of the ICMP error reply classifier: byte parser, record queue
// and verdict stage. Depends on iercl_pkg, iercl_parse, iercl_queue, iercl_judge.
//
// Usage: packet bytes enter on the input channel in wire order, one byte per
// cycle at most, with last_byte set on the final byte. For each packet one
// result leaves on the output channel: the verdict, the outer source address
// and the byte count (saturating at MAX_PACKET_BYTES).
// Throughput is one byte per cycle unless the queue is full; the parser captures
// header fields as the bytes stream by, with no per-packet gap between packets.
// The accepting edge of the last byte writes the record into the queue; it is
// loaded into the output register once that is empty or being drained.
// The queue holds four finished packet records; when the receiver stalls the
// queue fills and the input ready drops only once it is full. Configuration
// registers are written through the cfg channel (always ready) while no
// packet is in flight; this binds the user, the block does not enforce it.
// Reset is synchronous and active low; it restores the register defaults
// and empties the parser, queue and output.
module icmp_error_reply_classifier #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  iercl_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output iercl_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic                   push;
    logic                   full;
    logic                   pop;
    logic                   head_valid;
    iercl_pkg::t_packet_rec push_rec;
    iercl_pkg::t_packet_rec head_rec;

    // Front: byte parser.
    iercl_parse #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    // Queue of finished packet records.
    iercl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_rec   (head_rec)
    );

    // Back: verdict stage with configuration registers.
    iercl_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head_rec),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// File: src/iercl_parse.sv
// Byte parser: counts packet bytes and captures header fields as they pass.
// On the last byte it pushes the packet record into the queue.
// Depends on iercl_pkg.
module iercl_parse #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  iercl_pkg::t_in_item   i_item,
    input  logic                  i_full,
    output logic                  o_push,
    output iercl_pkg::t_packet_rec o_rec
);

    logic [15:0] r_count, n_count;
    logic [5:0]  r_outer_hdr, n_outer_hdr;
    logic [7:0]  r_outer_proto, n_outer_proto;
    logic [31:0] r_source, n_source;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_code, n_code;
    logic [5:0]  r_inner_hdr, n_inner_hdr;
    logic [7:0]  r_inner_proto, n_inner_proto;
    logic [15:0] r_port, n_port;
    logic [15:0] r_udp_len, n_udp_len;

    logic        accept;
    logic [7:0]  b;
    logic [5:0]  ihl_bytes;
    logic [5:0]  h_eff;
    logic [15:0] ofs_icmp;
    logic [15:0] ofs_inner;
    logic [15:0] ofs_udp;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_item.data_byte;

    // Header length nibble scaled to bytes.
    assign ihl_bytes = {b[3:0], 2'b00};

    // The outer length written by byte 0 is already in force for byte 0 itself.
    assign h_eff     = (r_count == 16'd0) ? ihl_bytes : r_outer_hdr;
    assign ofs_icmp  = {10'd0, h_eff};
    assign ofs_inner = ofs_icmp + iercl_pkg::ICMP_HDR_MIN;
    assign ofs_udp   = ofs_inner + {10'd0, r_inner_hdr};

    // Capture of this byte into the field registers it belongs to.
    always_comb begin
        n_count       = r_count;
        n_outer_hdr   = r_outer_hdr;
        n_outer_proto = r_outer_proto;
        n_source      = r_source;
        n_type        = r_type;
        n_code        = r_code;
        n_inner_hdr   = r_inner_hdr;
        n_inner_proto = r_inner_proto;
        n_port        = r_port;
        n_udp_len     = r_udp_len;
        if (r_count < 16'(MAX_PACKET_BYTES)) begin
            n_count = r_count + 16'd1;
            if (r_count == 16'd0) begin
                n_outer_hdr = ihl_bytes;
            end
            if (r_count == iercl_pkg::OFS_PROTOCOL) begin
                n_outer_proto = b;
            end
            if (r_count == iercl_pkg::OFS_SRC_BYTE0) begin
                n_source[31:24] = b;
            end
            if (r_count == iercl_pkg::OFS_SRC_BYTE1) begin
                n_source[23:16] = b;
            end
            if (r_count == iercl_pkg::OFS_SRC_BYTE2) begin
                n_source[15:8] = b;
            end
            if (r_count == iercl_pkg::OFS_SRC_BYTE3) begin
                n_source[7:0] = b;
            end
            if (r_count == ofs_icmp) begin
                n_type = b;
            end
            if (r_count == ofs_icmp + iercl_pkg::OFS_CODE) begin
                n_code = b;
            end
            if (r_count == ofs_inner) begin
                n_inner_hdr = ihl_bytes;
            end
            if (r_count == ofs_inner + iercl_pkg::OFS_PROTOCOL) begin
                n_inner_proto = b;
            end
            if (r_count == ofs_udp + iercl_pkg::OFS_PORT_HI) begin
                n_port[15:8] = b;
            end
            if (r_count == ofs_udp + iercl_pkg::OFS_PORT_LO) begin
                n_port[7:0] = b;
            end
            if (r_count == ofs_udp + iercl_pkg::OFS_LEN_HI) begin
                n_udp_len[15:8] = b;
            end
            if (r_count == ofs_udp + iercl_pkg::OFS_LEN_LO) begin
                n_udp_len[7:0] = b;
            end
        end
    end

    // The record includes what the last byte itself captured.
    always_comb begin
        o_rec.byte_count         = n_count;
        o_rec.outer_header_bytes = n_outer_hdr;
        o_rec.outer_protocol     = n_outer_proto;
        o_rec.reply_source       = n_source;
        o_rec.message_type       = n_type;
        o_rec.message_code       = n_code;
        o_rec.inner_header_bytes = n_inner_hdr;
        o_rec.inner_protocol     = n_inner_proto;
        o_rec.quoted_port        = n_port;
        o_rec.quoted_length      = n_udp_len;
    end

    assign o_push = accept && i_item.last_byte;

    // Per-packet state: updated on each byte, cleared after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_item.last_byte)) begin
            r_count       <= '0;
            r_outer_hdr   <= '0;
            r_outer_proto <= '0;
            r_source      <= '0;
            r_type        <= '0;
            r_code        <= '0;
            r_inner_hdr   <= '0;
            r_inner_proto <= '0;
            r_port        <= '0;
            r_udp_len     <= '0;
        end else if (accept) begin
            r_count       <= n_count;
            r_outer_hdr   <= n_outer_hdr;
            r_outer_proto <= n_outer_proto;
            r_source      <= n_source;
            r_type        <= n_type;
            r_code        <= n_code;
            r_inner_hdr   <= n_inner_hdr;
            r_inner_proto <= n_inner_proto;
            r_port        <= n_port;
            r_udp_len     <= n_udp_len;
        end
    end

endmodule

// File: src/iercl_queue.sv
// Short first-in first-out queue of packet records between parser and
// verdict stage. Depends on iercl_pkg.
module iercl_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  iercl_pkg::t_packet_rec i_rec,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output iercl_pkg::t_packet_rec o_rec
);

    iercl_pkg::t_packet_rec r_mem [iercl_pkg::QUEUE_DEPTH];

    logic [iercl_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [iercl_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [iercl_pkg::QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == iercl_pkg::QUEUE_CNT_W'(iercl_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/iercl_judge.sv
// Verdict stage: holds the configuration registers, classifies the record at
// the head of the queue and keeps the result in the output register.
// Depends on iercl_pkg.
module iercl_judge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_head_valid,
    input  iercl_pkg::t_packet_rec i_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output iercl_pkg::t_out_item   o_out_data
);

    logic [7:0]  r_exp_proto;
    logic [15:0] r_exp_port;
    logic [15:0] r_exp_len;

    logic                 r_out_valid;
    iercl_pkg::t_out_item r_out;

    iercl_pkg::t_verdict verdict;
    logic [15:0] n;
    logic [15:0] ofs_icmp_end;
    logic [15:0] ofs_inner_end;
    logic [15:0] ofs_udp_end;
    logic        load;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_proto <= iercl_pkg::RST_EXPECTED_PROTOCOL;
            r_exp_port  <= iercl_pkg::RST_EXPECTED_PORT;
            r_exp_len   <= iercl_pkg::RST_EXPECTED_UDP_LENGTH;
        end else if (i_cfg_valid) begin
            unique case (iercl_pkg::t_cfg_index'(i_cfg_index))
                iercl_pkg::CFG_EXPECTED_PROTOCOL:   r_exp_proto <= i_cfg_data[7:0];
                iercl_pkg::CFG_EXPECTED_PORT:       r_exp_port  <= i_cfg_data;
                iercl_pkg::CFG_EXPECTED_UDP_LENGTH: r_exp_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Length thresholds for each header in turn.
    assign n             = i_head.byte_count;
    assign ofs_icmp_end  = {10'd0, i_head.outer_header_bytes} + iercl_pkg::ICMP_HDR_MIN;
    assign ofs_inner_end = ofs_icmp_end + iercl_pkg::IP_HDR_MIN;
    assign ofs_udp_end   = ofs_icmp_end + {10'd0, i_head.inner_header_bytes}
                           + iercl_pkg::UDP_HDR;

    // Checks in priority order, then the class by ICMP type and code.
    always_comb begin
        if (n < iercl_pkg::IP_HDR_MIN) begin
            verdict = iercl_pkg::VERDICT_SHORT;
        end else if (i_head.outer_protocol != r_exp_proto) begin
            verdict = iercl_pkg::VERDICT_WRONG_PROTO;
        end else if (n < ofs_icmp_end) begin
            verdict = iercl_pkg::VERDICT_SHORT;
        end else if (i_head.message_type != iercl_pkg::TYPE_TIME_EXCEEDED &&
                     i_head.message_type != iercl_pkg::TYPE_UNREACHABLE) begin
            verdict = iercl_pkg::VERDICT_IGNORED;
        end else if (n < ofs_inner_end) begin
            verdict = iercl_pkg::VERDICT_SHORT;
        end else if (i_head.inner_protocol != iercl_pkg::PROTO_UDP) begin
            verdict = iercl_pkg::VERDICT_NOT_UDP;
        end else if (n < ofs_udp_end) begin
            verdict = iercl_pkg::VERDICT_SHORT;
        end else if (i_head.quoted_port != r_exp_port ||
                     i_head.quoted_length != r_exp_len) begin
            verdict = iercl_pkg::VERDICT_MISMATCH;
        end else if (i_head.message_type == iercl_pkg::TYPE_TIME_EXCEEDED) begin
            verdict = iercl_pkg::VERDICT_VALID;
        end else if (i_head.message_code == iercl_pkg::CODE_PORT) begin
            verdict = iercl_pkg::VERDICT_LAST_HOP;
        end else if (i_head.message_code == iercl_pkg::CODE_PROHIBITED) begin
            verdict = iercl_pkg::VERDICT_FILTERED;
        end else begin
            verdict = iercl_pkg::VERDICT_ABORT;
        end
    end

    // Take the head whenever the output register is empty or being drained.
    assign load  = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.verdict        <= verdict;
            r_out.source_address <= i_head.reply_source;
            r_out.reply_length   <= i_head.byte_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: tb/tb_icmp_error_reply_classifier.sv
// Self-checking testbench for the ICMP error reply classifier top level.
// Streams IPv4 reply packets byte by byte, predicts each verdict in its own
// packet tracker and compares every reply. Depends on iercl_pkg and the RTL.
module tb_icmp_error_reply_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PKT       = 65535;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          REPORT_LIMIT  = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    iercl_pkg::t_in_item   i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    iercl_pkg::t_out_item  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = 2'd0;
    logic [15:0]           i_cfg_data = 16'd0;

    icmp_error_reply_classifier #(
        .MAX_PACKET_BYTES(MAX_PKT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mirror of the configuration registers.
    logic [7:0]  cfg_proto    = iercl_pkg::RST_EXPECTED_PROTOCOL;
    logic [15:0] cfg_port     = iercl_pkg::RST_EXPECTED_PORT;
    logic [15:0] cfg_udp_len  = iercl_pkg::RST_EXPECTED_UDP_LENGTH;

    // Per-packet capture state of the tracker.
    int unsigned pkt_bytes    = 0;
    int unsigned ip_hdr_len   = 0;
    int unsigned quoted_hdr_len = 0;
    logic [7:0]  ip_proto     = '0;
    logic [31:0] reply_src    = '0;
    logic [7:0]  msg_type     = '0;
    logic [7:0]  msg_code     = '0;
    logic [7:0]  quoted_proto = '0;
    logic [15:0] quoted_dport = '0;
    logic [15:0] quoted_ulen  = '0;

    iercl_pkg::t_out_item replies_due[$];
    logic [7:0]           frame[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int replies_checked = 0;
    int settings_used = 1;
    int verdict_seen[0:8];

    iercl_pkg::t_out_item got_reply;
    iercl_pkg::t_out_item want_reply;

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    // Verdict for the packet just completed, checks in priority order.
    function automatic iercl_pkg::t_verdict classify_reply();
        int unsigned icmp_end;
        icmp_end = ip_hdr_len + iercl_pkg::ICMP_HDR_MIN;
        if (pkt_bytes < iercl_pkg::IP_HDR_MIN) return iercl_pkg::VERDICT_SHORT;
        if (ip_proto != cfg_proto) return iercl_pkg::VERDICT_WRONG_PROTO;
        if (pkt_bytes < icmp_end) return iercl_pkg::VERDICT_SHORT;
        if (msg_type != iercl_pkg::TYPE_TIME_EXCEEDED &&
            msg_type != iercl_pkg::TYPE_UNREACHABLE) begin
            return iercl_pkg::VERDICT_IGNORED;
        end
        if (pkt_bytes < icmp_end + iercl_pkg::IP_HDR_MIN) return iercl_pkg::VERDICT_SHORT;
        if (quoted_proto != iercl_pkg::PROTO_UDP) return iercl_pkg::VERDICT_NOT_UDP;
        if (pkt_bytes < icmp_end + quoted_hdr_len + iercl_pkg::UDP_HDR) begin
            return iercl_pkg::VERDICT_SHORT;
        end
        if (quoted_dport != cfg_port || quoted_ulen != cfg_udp_len) begin
            return iercl_pkg::VERDICT_MISMATCH;
        end
        if (msg_type == iercl_pkg::TYPE_TIME_EXCEEDED) return iercl_pkg::VERDICT_VALID;
        if (msg_code == iercl_pkg::CODE_PORT) return iercl_pkg::VERDICT_LAST_HOP;
        if (msg_code == iercl_pkg::CODE_PROHIBITED) return iercl_pkg::VERDICT_FILTERED;
        return iercl_pkg::VERDICT_ABORT;
    endfunction

    // Capture one accepted byte; on the last byte queue the reply it yields.
    function automatic void absorb_byte(input iercl_pkg::t_in_item it);
        int unsigned p;
        int unsigned inner_at;
        int unsigned udp_at;
        logic [7:0]  b;
        iercl_pkg::t_out_item reply;
        p = pkt_bytes;
        b = it.data_byte;
        if (pkt_bytes < MAX_PKT) begin
            if (p == 0) ip_hdr_len = b[3:0] * 4;
            if (p == iercl_pkg::OFS_PROTOCOL) ip_proto = b;
            if (p >= iercl_pkg::OFS_SRC_BYTE0 && p <= iercl_pkg::OFS_SRC_BYTE3) begin
                reply_src[8 * (iercl_pkg::OFS_SRC_BYTE3 - p) +: 8] = b;
            end
            if (p == ip_hdr_len) msg_type = b;
            if (p == ip_hdr_len + iercl_pkg::OFS_CODE) msg_code = b;
            inner_at = ip_hdr_len + iercl_pkg::ICMP_HDR_MIN;
            if (p == inner_at) quoted_hdr_len = b[3:0] * 4;
            if (p == inner_at + iercl_pkg::OFS_PROTOCOL) quoted_proto = b;
            udp_at = inner_at + quoted_hdr_len;
            if (p == udp_at + iercl_pkg::OFS_PORT_HI) quoted_dport[15:8] = b;
            if (p == udp_at + iercl_pkg::OFS_PORT_LO) quoted_dport[7:0] = b;
            if (p == udp_at + iercl_pkg::OFS_LEN_HI) quoted_ulen[15:8] = b;
            if (p == udp_at + iercl_pkg::OFS_LEN_LO) quoted_ulen[7:0] = b;
            pkt_bytes++;
        end
        if (it.last_byte) begin
            reply.verdict        = classify_reply();
            reply.source_address = reply_src;
            reply.reply_length   = pkt_bytes[15:0];
            replies_due.push_back(reply);
            pkt_bytes      = 0;
            ip_hdr_len     = 0;
            quoted_hdr_len = 0;
            ip_proto       = '0;
            reply_src      = '0;
            msg_type       = '0;
            msg_code       = '0;
            quoted_proto   = '0;
            quoted_dport   = '0;
            quoted_ulen    = '0;
        end
    endfunction

    // Receiver side: random stalls on the reply channel.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every accepted reply with the oldest predicted one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_reply = o_out_data;
            if (replies_due.size() == 0) begin
                note_error($sformatf("unexpected reply: verdict %0d src %h len %0d",
                    got_reply.verdict, got_reply.source_address, got_reply.reply_length));
            end else begin
                want_reply = replies_due.pop_front();
                if (got_reply.verdict !== want_reply.verdict ||
                    got_reply.source_address !== want_reply.source_address ||
                    got_reply.reply_length !== want_reply.reply_length) begin
                    note_error($sformatf(
                        "reply %0d differs: want verdict %0d src %h len %0d, got %0d %h %0d",
                        replies_checked, want_reply.verdict, want_reply.source_address,
                        want_reply.reply_length, got_reply.verdict,
                        got_reply.source_address, got_reply.reply_length));
                end
                verdict_seen[want_reply.verdict]++;
                replies_checked++;
            end
        end
    end

    // Send one byte request, with a random idle gap in front of it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        iercl_pkg::t_in_item item;
        item.data_byte = b;
        item.last_byte = last;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_byte(item);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) begin
            send_byte(frame[i], i == frame.size() - 1);
        end
        packets_sent++;
    endtask

    // Build an ICMP error packet quoting an IPv4/UDP probe; filler is random.
    function automatic void make_reply(input int ihl, input logic [7:0] proto,
            input logic [31:0] src, input logic [7:0] mtype, input logic [7:0] mcode,
            input int ihl_in, input logic [7:0] iproto, input logic [15:0] port,
            input logic [15:0] udp_len, input int extra);
        int icmp_at;
        int inner_at;
        int udp_at;
        int total;
        logic [7:0] tmp;
        icmp_at  = ihl * 4;
        inner_at = icmp_at + iercl_pkg::ICMP_HDR_MIN;
        udp_at   = inner_at + ihl_in * 4;
        total    = udp_at + iercl_pkg::UDP_HDR;
        if (total < inner_at + iercl_pkg::IP_HDR_MIN) begin
            total = inner_at + iercl_pkg::IP_HDR_MIN;
        end
        total += extra;
        frame.delete();
        repeat (total) frame.push_back(8'($urandom));
        tmp = frame[0];
        frame[0] = {tmp[7:4], 4'(ihl)};
        frame[iercl_pkg::OFS_PROTOCOL] = proto;
        for (int k = 0; k < 4; k++) begin
            frame[iercl_pkg::OFS_SRC_BYTE0 + k] = src[8 * (3 - k) +: 8];
        end
        frame[icmp_at] = mtype;
        frame[icmp_at + iercl_pkg::OFS_CODE] = mcode;
        tmp = frame[inner_at];
        frame[inner_at] = {tmp[7:4], 4'(ihl_in)};
        frame[inner_at + iercl_pkg::OFS_PROTOCOL] = iproto;
        frame[udp_at + iercl_pkg::OFS_PORT_HI] = port[15:8];
        frame[udp_at + iercl_pkg::OFS_PORT_LO] = port[7:0];
        frame[udp_at + iercl_pkg::OFS_LEN_HI]  = udp_len[15:8];
        frame[udp_at + iercl_pkg::OFS_LEN_LO]  = udp_len[7:0];
    endfunction

    // Build, optionally truncate to keep bytes, and send one reply packet.
    task automatic send_reply(input int ihl, input logic [7:0] proto, input logic [31:0] src,
            input logic [7:0] mtype, input logic [7:0] mcode, input int ihl_in,
            input logic [7:0] iproto, input logic [15:0] port, input logic [15:0] udp_len,
            input int keep);
        make_reply(ihl, proto, src, mtype, mcode, ihl_in, iproto, port, udp_len,
                   $urandom_range(0, 4));
        if (keep > 0) begin
            while (frame.size() > keep) void'(frame.pop_back());
        end
        send_frame();
    endtask

    // Lower valid and wait for every predicted reply, then let the pipeline settle.
    task automatic wait_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (replies_due.size() != 0) begin
            note_error($sformatf("%0d replies never arrived", replies_due.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input iercl_pkg::t_cfg_index idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            iercl_pkg::CFG_EXPECTED_PROTOCOL:   cfg_proto = value[7:0];
            iercl_pkg::CFG_EXPECTED_PORT:       cfg_port = value;
            iercl_pkg::CFG_EXPECTED_UDP_LENGTH: cfg_udp_len = value;
            default: ;
        endcase
    endtask

    // Write all three registers while the block is idle.
    task automatic write_settings(input logic [7:0] proto, input logic [15:0] port,
            input logic [15:0] udp_len);
        wait_drained();
        // Upper data bits of the protocol write are junk the register must drop.
        put_reg(iercl_pkg::CFG_EXPECTED_PROTOCOL, {8'($urandom), proto});
        put_reg(iercl_pkg::CFG_EXPECTED_PORT, port);
        put_reg(iercl_pkg::CFG_EXPECTED_UDP_LENGTH, udp_len);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_ihl();
        return ($urandom_range(9) < 7) ? 5 : $urandom_range(15);
    endfunction

    // One random packet: mostly well-formed replies with random faults, some noise.
    task automatic random_packet();
        int          full;
        logic [7:0]  mtype;
        logic [7:0]  mcode;
        if ($urandom_range(99) < 20) begin
            frame.delete();
            repeat ($urandom_range(1, 64)) frame.push_back(8'($urandom));
            send_frame();
        end else begin
            case ($urandom_range(9))
                0:       mtype = 8'($urandom);
                1, 2, 3, 4: mtype = iercl_pkg::TYPE_TIME_EXCEEDED;
                default: mtype = iercl_pkg::TYPE_UNREACHABLE;
            endcase
            case ($urandom_range(3))
                0:       mcode = iercl_pkg::CODE_PORT;
                1:       mcode = iercl_pkg::CODE_PROHIBITED;
                2:       mcode = 8'($urandom_range(15));
                default: mcode = 8'($urandom);
            endcase
            make_reply(pick_ihl(),
                       ($urandom_range(9) == 0) ? 8'($urandom) : cfg_proto,
                       $urandom, mtype, mcode, pick_ihl(),
                       ($urandom_range(9) == 0) ? 8'($urandom) : iercl_pkg::PROTO_UDP,
                       ($urandom_range(9) == 0) ? 16'($urandom) : cfg_port,
                       ($urandom_range(9) == 0) ? 16'($urandom) : cfg_udp_len,
                       $urandom_range(0, 6));
            full = frame.size();
            if ($urandom_range(99) < 15) begin
                full = $urandom_range(1, full);
                while (frame.size() > full) void'(frame.pop_back());
            end
            send_frame();
        end
    endtask

    task automatic random_traffic(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) random_packet();
    endtask

    // Length checks inside each header in turn, and the outer protocol check.
    task automatic test_short_and_protocol();
        frame.delete();
        frame.push_back(8'hFF);
        send_frame();
        frame.delete();
        repeat (19) frame.push_back(8'h00);
        send_frame();
        send_reply(5, cfg_proto ^ 8'h01, 32'hFFFF_FFFF, iercl_pkg::TYPE_TIME_EXCEEDED,
                   8'd0, 5, iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 0);
        // Truncated inside the ICMP header with the largest outer header.
        send_reply(15, cfg_proto, 32'h0, iercl_pkg::TYPE_UNREACHABLE, iercl_pkg::CODE_PORT,
                   5, iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 62);
        // Truncated inside the quoted IP header.
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_TIME_EXCEEDED, 8'd0, 5,
                   iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 40);
        // Truncated inside the quoted UDP header behind a long quoted IP header.
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_TIME_EXCEEDED, 8'd0, 15,
                   iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 90);
    endtask

    // One packet per verdict class from the type, code and quoted fields, two for mismatch.
    task automatic test_verdict_classes();
        send_reply(5, cfg_proto, $urandom, 8'd0, 8'd0, 5, iercl_pkg::PROTO_UDP,
                   cfg_port, cfg_udp_len, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_TIME_EXCEEDED, 8'd0, 5, 8'd6,
                   cfg_port, cfg_udp_len, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_UNREACHABLE, iercl_pkg::CODE_PORT,
                   5, iercl_pkg::PROTO_UDP, cfg_port ^ 16'h0100, cfg_udp_len, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_UNREACHABLE, iercl_pkg::CODE_PORT,
                   5, iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len ^ 16'h0001, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_TIME_EXCEEDED, 8'd1, 5,
                   iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_UNREACHABLE, iercl_pkg::CODE_PORT,
                   5, iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_UNREACHABLE,
                   iercl_pkg::CODE_PROHIBITED, 5, iercl_pkg::PROTO_UDP,
                   cfg_port, cfg_udp_len, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_UNREACHABLE, 8'd1, 5,
                   iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 0);
    endtask

    // Header lengths below the minimum, where fields share bytes.
    task automatic test_header_lengths();
        // Outer header length zero: the first byte doubles as the ICMP type.
        send_reply(0, cfg_proto, $urandom, 8'h00, 8'd0, 5, iercl_pkg::PROTO_UDP,
                   cfg_port, cfg_udp_len, 20);
        send_reply(3, cfg_proto, $urandom, iercl_pkg::TYPE_TIME_EXCEEDED, 8'd0, 5,
                   iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 0);
        send_reply(5, cfg_proto, $urandom, iercl_pkg::TYPE_UNREACHABLE, iercl_pkg::CODE_PORT,
                   0, iercl_pkg::PROTO_UDP, cfg_port, cfg_udp_len, 0);
        send_reply(1, cfg_proto, $urandom, iercl_pkg::TYPE_UNREACHABLE,
                   iercl_pkg::CODE_PROHIBITED, 2, iercl_pkg::PROTO_UDP,
                   cfg_port, cfg_udp_len, 0);
    endtask

    // Register extremes and random values, each with a burst of traffic.
    task automatic test_config_sweep();
        write_settings(8'd0, 16'd0, 16'd12);
        random_traffic(60);
        write_settings(8'd255, 16'hFFFF, 16'hFFFF);
        random_traffic(60);
        write_settings(8'($urandom), 16'($urandom), 16'($urandom_range(12, 65535)));
        random_traffic(60);
        write_settings(iercl_pkg::RST_EXPECTED_PROTOCOL, 16'($urandom),
                       iercl_pkg::RST_EXPECTED_UDP_LENGTH);
        random_traffic(60);
    endtask

    // Random traffic with one pause until every reply is back.
    task automatic test_traffic_with_pause();
        write_settings(iercl_pkg::RST_EXPECTED_PROTOCOL, 16'($urandom),
                       16'($urandom_range(12, 600)));
        random_traffic(120);
        wait_drained();
        random_traffic(120);
    endtask

    // Back-to-back traffic with no idle cycles on either side.
    task automatic test_back_to_back();
        write_settings(iercl_pkg::RST_EXPECTED_PROTOCOL, 16'($urandom),
                       16'($urandom_range(12, 65535)));
        random_traffic(160);
    endtask

    initial begin
        string               tally;
        iercl_pkg::t_verdict vname;
        for (int v = 0; v <= 8; v++) verdict_seen[v] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 37;
        recv_idle_pct = 52;
        test_short_and_protocol();
        test_verdict_classes();
        test_header_lengths();
        test_config_sweep();

        send_idle_pct = 52;
        recv_idle_pct = 37;
        test_traffic_with_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_to_back();

        wait_drained();
        errors += replies_due.size();
        tally = "";
        for (int v = 0; v <= 8; v++) begin
            vname = iercl_pkg::t_verdict'(4'(v));
            tally = {tally, $sformatf(" %s=%0d", vname.name(), verdict_seen[v])};
        end
        $display("Sent %0d packets (%0d bytes) under %0d register settings, %0d replies checked.",
                 packets_sent, bytes_sent, settings_used, replies_checked);
        $display("Verdicts covered:%s", tally);
        if (errors == 0) begin
            $display("icmp_error_reply_classifier: match");
        end else begin
            $display("icmp_error_reply_classifier: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20_000_000;
        $display("Timed out with %0d replies outstanding.", replies_due.size());
        $display("icmp_error_reply_classifier: mismatch");
        $finish;
    end

endmodule
